FILE: src/ccq_pkg.sv
// Package for the coalescing command queue: sizes, codes and packed
// transfer and entry layouts. No dependencies.
package ccq_pkg;

	localparam int DEPTH = 32;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);

	localparam logic [4:0] MAX_PENDING_RESET = 5'd20;

	localparam logic [1:0] CMD_APPEND  = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_EXECUTE = 2'd2;
	localparam logic [1:0] CMD_PEEK    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	localparam logic CFG_MAX_PENDING = 1'b0;
	localparam logic CFG_WARNING_ID  = 1'b1;

	typedef struct packed {
		logic        sent;
		logic [7:0]  count;
		logic [31:0] payload;
		logic [7:0]  sub_key;
		logic [5:0]  id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] payload;
		logic [7:0]  sub_key;
		logic [5:0]  action_id;
	} in_data_t;

	typedef struct packed {
		logic [5:0]  occupancy;
		logic [7:0]  inherited_count;
		logic        head_executed;
		logic [7:0]  head_send_count;
		logic [31:0] head_payload;
		logic [7:0]  head_sub_key;
		logic [5:0]  head_id;
		logic        head_valid;
		logic [1:0]  status;
	} result_t;

	localparam int IN_W  = $bits(in_data_t);
	localparam int OUT_W = $bits(result_t);

endpackage

FILE: src/ccq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ccq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/coalescing_command_queue_core.sv
// Coalescing command queue top level: sequencer around one entry RAM.
// Depends on ccq_pkg and ccq_ram.
// An append searches for a match, compacts the queue past a matching entry (one RAM read
// and one write per cycle) and then inserts the new entry; a pop compacts without a search.
// One command at a time; a new command is taken while the previous result waits.
// Reset clears fill level, registers (max_pending 20, warning id 0) and output valid.
module coalescing_command_queue_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// action_id[5:0], sub_key[13:6], payload[45:14], zero pad
	input  logic [ccq_pkg::IN_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[1:0], head_valid[2], head_id[8:3], head_sub_key[16:9],
	// head_payload[48:17], head_send_count[56:49], head_executed[57],
	// inherited_count[65:58], occupancy[71:66]
	output logic [ccq_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic                  cfg_addr,
	input  logic [5:0]            cfg_wdata
);
	import ccq_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_SHIFT   = 3'd2;
	localparam logic [2:0] S_INSERT  = 3'd3;
	localparam logic [2:0] S_EXEC_RD = 3'd4;
	localparam logic [2:0] S_EXEC_WR = 3'd5;
	localparam logic [2:0] S_HEAD_RD = 3'd6;
	localparam logic [2:0] S_HEAD_CK = 3'd7;

	logic [2:0]    state_q;
	logic [FW-1:0] fill_q;
	logic [4:0]    max_pending_q;
	logic [5:0]    warn_id_q;
	logic          out_valid_q;
	result_t       out_q;

	logic [1:0]    cmd_q;
	logic [5:0]    id_q;
	logic [7:0]    key_q;
	logic [31:0]   pay_q;
	logic          warn_q;
	logic [1:0]    status_q;
	logic [7:0]    inherited_q;

	logic [FW-1:0] idx_q;
	logic          pend_s1;
	logic [FW-1:0] addr_s1;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;
	logic [FW-1:0] shift_dst;

	in_data_t      in_d;
	logic          accept;
	logic          out_free;
	logic          match;
	logic          more;
	logic          reject;

	assign in_d          = in_data_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign match = (ram_rdata.id == id_q) && (!warn_q || (ram_rdata.sub_key == key_q));
	assign more  = (idx_q < fill_q);
	assign reject = (fill_q >= FW'(DEPTH)) ||
	                ((fill_q != '0) && (fill_q > FW'(max_pending_q)));
	assign shift_dst = addr_s1 - FW'(1);

	ccq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_SCAN: begin
				ram_re = more;
			end
			S_SHIFT: begin
				ram_re    = more;
				ram_we    = pend_s1;
				ram_waddr = shift_dst[AW-1:0];
			end
			S_INSERT: begin
				ram_we            = !reject;
				ram_waddr         = fill_q[AW-1:0];
				ram_wdata.id      = id_q;
				ram_wdata.sub_key = key_q;
				ram_wdata.payload = pay_q;
				ram_wdata.count   = inherited_q;
				ram_wdata.sent    = 1'b0;
			end
			S_EXEC_RD, S_HEAD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_EXEC_WR: begin
				ram_we          = 1'b1;
				ram_waddr       = '0;
				ram_wdata.sent  = 1'b1;
				ram_wdata.count = (ram_rdata.count != 8'hFF) ? ram_rdata.count + 8'd1
				                                             : ram_rdata.count;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			max_pending_q <= MAX_PENDING_RESET;
			warn_id_q     <= '0;
			out_valid_q   <= 1'b0;
			pend_s1       <= 1'b0;
			addr_s1       <= '0;
			idx_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_MAX_PENDING: max_pending_q <= cfg_wdata[4:0];
					CFG_WARNING_ID:  warn_id_q     <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						if (s_axis_tuser == CMD_APPEND) begin
							idx_q   <= '0;
							state_q <= (fill_q == '0) ? S_INSERT : S_SCAN;
						end else if (fill_q == '0) begin
							state_q <= S_HEAD_RD;
						end else if (s_axis_tuser == CMD_POP) begin
							idx_q   <= FW'(1);
							state_q <= S_SHIFT;
						end else if (s_axis_tuser == CMD_EXECUTE) begin
							state_q <= S_EXEC_RD;
						end else begin
							state_q <= S_HEAD_RD;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= more;
					addr_s1 <= idx_q;
					if (more) begin
						idx_q <= idx_q + FW'(1);
					end
					if (pend_s1 && match) begin
						pend_s1 <= 1'b0;
						idx_q   <= addr_s1 + FW'(1);
						state_q <= S_SHIFT;
					end else if (!pend_s1 && !more) begin
						state_q <= S_INSERT;
					end
				end
				S_SHIFT: begin
					pend_s1 <= more;
					addr_s1 <= idx_q;
					if (more) begin
						idx_q <= idx_q + FW'(1);
					end
					if (!pend_s1 && !more) begin
						fill_q  <= fill_q - FW'(1);
						state_q <= (cmd_q == CMD_APPEND) ? S_INSERT : S_HEAD_RD;
					end
				end
				S_INSERT: begin
					if (!reject) begin
						fill_q <= fill_q + FW'(1);
					end
					state_q <= S_HEAD_RD;
				end
				S_EXEC_RD: begin
					state_q <= S_EXEC_WR;
				end
				S_EXEC_WR: begin
					state_q <= S_HEAD_RD;
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_CK;
				end
				S_HEAD_CK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= s_axis_tuser;
			id_q        <= in_d.action_id;
			key_q       <= in_d.sub_key;
			pay_q       <= in_d.payload;
			warn_q      <= (in_d.action_id == warn_id_q);
			inherited_q <= '0;
			status_q    <= ((s_axis_tuser != CMD_APPEND) && (fill_q == '0)) ? ST_EMPTY : ST_OK;
		end
		if ((state_q == S_SCAN) && pend_s1 && match) begin
			inherited_q <= ram_rdata.count;
		end
		if ((state_q == S_INSERT) && reject) begin
			status_q <= ST_REJECTED;
		end
		if ((state_q == S_HEAD_CK) && out_free) begin
			out_q.status          <= status_q;
			out_q.head_valid      <= (fill_q != '0);
			out_q.head_id         <= (fill_q != '0) ? ram_rdata.id : '0;
			out_q.head_sub_key    <= (fill_q != '0) ? ram_rdata.sub_key : '0;
			out_q.head_payload    <= (fill_q != '0) ? ram_rdata.payload : '0;
			out_q.head_send_count <= (fill_q != '0) ? ram_rdata.count : '0;
			out_q.head_executed   <= (fill_q != '0) ? ram_rdata.sent : 1'b0;
			out_q.inherited_count <= inherited_q;
			out_q.occupancy       <= 6'(fill_q);
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for coalescing_command_queue_core: directed and random command
// streams, checked result by result against an in-bench queue predictor. Depends on ccq_pkg.
module tb_top;
	import ccq_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata  = '0;
	logic [1:0]          s_axis_tuser  = CMD_PEEK;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                cfg_we        = 1'b0;
	logic                cfg_addr      = CFG_MAX_PENDING;
	logic [5:0]          cfg_wdata     = '0;

	// predictor state
	entry_t              model_entries[$];
	logic [4:0]          model_max_pending = MAX_PENDING_RESET;
	logic [5:0]          model_warn_id     = '0;
	result_t             queue_reports[$];

	int                  mismatch_count = 0;
	int                  idle_cycles    = 0;
	int                  src_idle_pct   = 0;
	int                  sink_stall_pct = 0;
	int                  sink_hold_req  = 0;
	int                  sink_hold_left = 0;
	result_t             seen_result;
	result_t             want_result;

	coalescing_command_queue_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t predict_queue_op(input logic [1:0] cmd, input logic [5:0] id,
			input logic [7:0] key, input logic [31:0] pay);
		result_t r;
		entry_t  e;
		int      hit;
		int      i;
		r   = '0;
		hit = -1;
		case (cmd)
		CMD_APPEND: begin
			for (i = 0; i < model_entries.size() && hit < 0; i++) begin
				if (model_entries[i].id == id &&
						(id != model_warn_id || model_entries[i].sub_key == key))
					hit = i;
			end
			if (hit >= 0) begin
				r.inherited_count = model_entries[hit].count;
				model_entries.delete(hit);
			end
			if (model_entries.size() >= DEPTH ||
					(model_entries.size() != 0 && model_entries.size() > model_max_pending)) begin
				r.status = ST_REJECTED;
			end else begin
				e.id      = id;
				e.sub_key = key;
				e.payload = pay;
				e.count   = r.inherited_count;
				e.sent    = 1'b0;
				model_entries.push_back(e);
			end
		end
		default: begin
			if (model_entries.size() == 0) begin
				r.status = ST_EMPTY;
			end else if (cmd == CMD_POP) begin
				model_entries.delete(0);
			end else if (cmd == CMD_EXECUTE) begin
				model_entries[0].sent = 1'b1;
				if (model_entries[0].count != 8'hff)
					model_entries[0].count = model_entries[0].count + 8'd1;
			end
		end
		endcase
		if (model_entries.size() != 0) begin
			r.head_valid      = 1'b1;
			r.head_id         = model_entries[0].id;
			r.head_sub_key    = model_entries[0].sub_key;
			r.head_payload    = model_entries[0].payload;
			r.head_send_count = model_entries[0].count;
			r.head_executed   = model_entries[0].sent;
		end
		r.occupancy = 6'(model_entries.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_result = m_axis_tdata;
			if (queue_reports.size() == 0) begin
				report_mismatch("unexpected transfer", 32'(seen_result.occupancy), 32'd0);
			end else begin
				want_result = queue_reports.pop_front();
				check_field("status", 32'(seen_result.status), 32'(want_result.status));
				check_field("head_valid", 32'(seen_result.head_valid),
					32'(want_result.head_valid));
				check_field("head_id", 32'(seen_result.head_id), 32'(want_result.head_id));
				check_field("head_sub_key", 32'(seen_result.head_sub_key),
					32'(want_result.head_sub_key));
				check_field("head_payload", seen_result.head_payload, want_result.head_payload);
				check_field("head_send_count", 32'(seen_result.head_send_count),
					32'(want_result.head_send_count));
				check_field("head_executed", 32'(seen_result.head_executed),
					32'(want_result.head_executed));
				check_field("inherited_count", 32'(seen_result.inherited_count),
					32'(want_result.inherited_count));
				check_field("occupancy", 32'(seen_result.occupancy),
					32'(want_result.occupancy));
			end
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (sink_hold_req > 0) begin
			sink_hold_left = sink_hold_req;
			sink_hold_req  = 0;
		end
		if (sink_hold_left > 0) begin
			sink_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_op(input logic [1:0] cmd, input logic [5:0] id, input logic [7:0] key,
			input logic [31:0] pay);
		in_data_t d;
		int       gap;
		d           = '0;
		d.action_id = id;
		d.sub_key   = key;
		d.payload   = pay;
		if ($urandom_range(0, 99) < src_idle_pct) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		queue_reports.push_back(predict_queue_op(cmd, id, key, pay));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (queue_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [4:0] max_pending, input logic [5:0] warn_id);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MAX_PENDING;
		cfg_wdata <= {1'b0, max_pending};
		@(posedge clk);
		cfg_addr  <= CFG_WARNING_ID;
		cfg_wdata <= warn_id;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		model_max_pending = max_pending;
		model_warn_id     = warn_id;
	endtask

	// reset register values, empty-queue commands, merge rules, field extremes
	task automatic test_directed();
		send_op(CMD_PEEK, 6'd0, 8'd0, 32'h0);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_APPEND, 6'd0, 8'd1, 32'h0000_0000);
		send_op(CMD_APPEND, 6'd0, 8'd2, 32'hffff_ffff);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_APPEND, 6'd0, 8'd1, 32'h1234_5678);
		send_op(CMD_APPEND, 6'd63, 8'd255, 32'hffff_ffff);
		send_op(CMD_APPEND, 6'd63, 8'd0, 32'h8000_0001);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_APPEND, 6'd0, 8'd2, 32'h5a5a_a5a5);
		send_op(CMD_PEEK, 6'd63, 8'd255, 32'hffff_ffff);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		drain_results();
	endtask

	task automatic test_count_saturation();
		send_op(CMD_APPEND, 6'd5, 8'd9, 32'hcafe_f00d);
		repeat (257) send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_APPEND, 6'd5, 8'd0, 32'h0bad_beef);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		drain_results();
	endtask

	// limit extremes, warning-id merging, full storage, rejected merge
	task automatic test_queue_limits();
		int i;
		write_regs(5'd0, 6'd63);
		send_op(CMD_APPEND, 6'd1, 8'd7, 32'h1);
		send_op(CMD_APPEND, 6'd2, 8'd7, 32'h2);
		send_op(CMD_APPEND, 6'd1, 8'd8, 32'h3);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_APPEND, 6'd1, 8'd9, 32'h4);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		drain_results();
		write_regs(5'd31, 6'd63);
		send_op(CMD_APPEND, 6'd63, 8'd3, 32'h10);
		send_op(CMD_APPEND, 6'd63, 8'd4, 32'h11);
		send_op(CMD_APPEND, 6'd63, 8'd3, 32'h12);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		for (i = 0; i < DEPTH; i++)
			send_op(CMD_APPEND, i[5:0], 8'd0, $urandom);
		send_op(CMD_APPEND, 6'd40, 8'd0, 32'h40);
		send_op(CMD_APPEND, 6'd10, 8'd0, 32'h41);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		send_op(CMD_EXECUTE, 6'd0, 8'd0, 32'h0);
		drain_results();
		write_regs(5'd1, 6'd0);
		send_op(CMD_APPEND, 6'd0, 8'd0, 32'h42);
		repeat (DEPTH) send_op(CMD_POP, 6'd0, 8'd0, 32'h0);
		drain_results();
	endtask

	task automatic run_random_phase(input int count, input int src_pct, input int sink_pct,
			input logic [4:0] max_pending, input logic [5:0] warn_id);
		int          n;
		int          pick;
		int          sel;
		logic [1:0]  cmd;
		logic [5:0]  id;
		logic [7:0]  key;
		write_regs(max_pending, warn_id);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				cmd = CMD_APPEND;
			else if (pick < 70)
				cmd = CMD_POP;
			else if (pick < 90)
				cmd = CMD_EXECUTE;
			else
				cmd = CMD_PEEK;
			sel = $urandom_range(0, 9);
			if (sel < 4)
				id = model_warn_id;
			else if (sel < 8)
				id = 6'($urandom_range(0, 3));
			else
				id = 6'($urandom_range(0, 63));
			if ($urandom_range(0, 9) < 6)
				key = 8'($urandom_range(0, 3));
			else
				key = 8'($urandom_range(0, 255));
			send_op(cmd, id, key, $urandom);
			if ($urandom_range(0, 199) == 0)
				drain_results();
		end
		drain_results();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		int n;
		write_regs(5'd20, 6'd9);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		sink_hold_req  = 300;
		for (n = 0; n < 16; n++)
			send_op((n % 3 == 0) ? CMD_PEEK : CMD_APPEND, 6'($urandom_range(0, 63)),
				8'($urandom_range(0, 255)), $urandom);
		drain_results();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_count_saturation();
		test_queue_limits();
		run_random_phase(260, 0, 0, 5'd31, 6'd63);
		run_random_phase(260, 50, 0, 5'd20, 6'd0);
		run_random_phase(260, 0, 50, 5'd8, 6'd17);
		run_random_phase(260, 7, 7, 5'd31, 6'($urandom_range(0, 63)));
		test_backpressure();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
src/ccq_pkg.sv
src/ccq_ram.sv
src/coalescing_command_queue_core.sv
tb/sv/tb_top.sv
